FILE: src/i2cra_pkg.sv
// shared types and constants for the i2c master register access core
package i2cra_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;

    localparam logic [7:0] STATUS_MASK  = 8'hF8;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RSTART    = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_RX_NACK   = 8'h58;

    typedef enum logic [1:0] {
        MODE_START_WR = 2'd0,
        MODE_START_RD = 2'd1,
        MODE_STATUS   = 2'd2,
        MODE_LOAD     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_START  = 3'd1,
        ACT_SEND   = 3'd2,
        ACT_RSTART = 3'd3,
        ACT_STOP   = 3'd4,
        ACT_RECV   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] status_code;
        logic [7:0] bus_byte;
        logic [7:0] buffer_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] send_byte;
        logic       ack_next;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic       read_done;
        logic       error;
        logic       bus_free;
    } out_item_t;

    // result of one transaction before the buffer byte is merged in
    typedef struct packed {
        out_item_t item;
        logic      from_buf;
    } seq_res_t;

    // access request towards the transmit buffer
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [7:0] rd_addr;
    } buf_req_t;

endpackage

FILE: src/i2cra_buf.sv
// transmit byte buffer: one write and one registered read port
module i2cra_buf #(
    parameter int BUFFER_DEPTH = i2cra_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                aclk,
    input  i2cra_pkg::buf_req_t req,
    output logic [7:0]          rd_data
);
    import i2cra_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        // data only moves on a read so it holds while the result stalls
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

    a_no_dual_access: assert property (@(posedge aclk)
        !(req.wr_en && req.rd_en))
        else $error("buffer read and write in the same cycle");

endmodule

FILE: src/i2cra_seq.sv
// transfer sequencer: decodes each transaction and updates the transfer state
module i2cra_seq #(
    parameter int BUFFER_DEPTH = i2cra_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  i2cra_pkg::in_item_t in_item,
    output i2cra_pkg::seq_res_t res,
    output i2cra_pkg::buf_req_t buf_req
);
    import i2cra_pkg::*;

    localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

    logic       idle_reg, idle_next;
    op_t        op_reg, op_next;
    logic [6:0] addr_reg, addr_next;
    logic [7:0] regad_reg, regad_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;

    logic [7:0]        status;
    logic [7:0]        cnt_inc;
    logic signed [9:0] remain;
    mode_t             mode;

    assign mode    = mode_t'(in_item.mode);
    assign status  = in_item.status_code & STATUS_MASK;
    assign cnt_inc = cnt_reg + 8'd1;
    assign remain  = $signed({2'b00, len_reg}) - $signed({2'b00, cnt_inc});

    always_comb begin
        idle_next  = idle_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        regad_next = regad_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        res        = '0;
        buf_req    = '0;
        buf_req.wr_addr = in_item.buffer_index;
        buf_req.wr_data = in_item.bus_byte;
        buf_req.rd_addr = cnt_reg;

        case (mode)
            MODE_START_WR, MODE_START_RD: begin
                if (idle_reg) begin
                    addr_next  = in_item.slave_address;
                    regad_next = in_item.register_address;
                    len_next   = in_item.byte_count;
                    op_next    = (mode == MODE_START_WR) ? OP_WRITE : OP_READ;
                    idle_next  = 1'b0;
                    res.item.action = ACT_START;
                end
            end
            MODE_STATUS: begin
                if (op_reg == OP_WRITE || op_reg == OP_READ) begin
                    case (status)
                        ST_START: begin
                            cnt_next = '0;
                            res.item.action    = ACT_SEND;
                            res.item.send_byte = {addr_reg, 1'b0};
                        end
                        ST_SLAW_ACK: begin
                            res.item.action    = ACT_SEND;
                            res.item.send_byte = regad_reg;
                        end
                        ST_DATA_ACK: begin
                            if (op_reg == OP_READ) begin
                                res.item.action = ACT_RSTART;
                            end else if (cnt_reg < len_reg) begin
                                // byte comes from the registered buffer read and is merged in the holding stage
                                res.item.action = ACT_SEND;
                                res.from_buf    = ({1'b0, cnt_reg} < DEPTH9);
                                buf_req.rd_en   = res.from_buf;
                                cnt_next        = cnt_inc;
                            end else begin
                                res.item.action = ACT_STOP;
                                idle_next       = 1'b1;
                            end
                        end
                        ST_RSTART: begin
                            if (op_reg == OP_READ) begin
                                res.item.action    = ACT_SEND;
                                res.item.send_byte = {addr_reg, 1'b1};
                            end else begin
                                res.item.action = ACT_STOP;
                                res.item.error  = 1'b1;
                                idle_next       = 1'b1;
                            end
                        end
                        ST_SLAR_ACK: begin
                            if (op_reg == OP_READ) begin
                                res.item.action   = ACT_RECV;
                                res.item.ack_next = (len_reg > 8'd1);
                            end else begin
                                res.item.action = ACT_STOP;
                                res.item.error  = 1'b1;
                                idle_next       = 1'b1;
                            end
                        end
                        ST_RX_ACK: begin
                            if (op_reg == OP_READ) begin
                                res.item.rx_valid = 1'b1;
                                res.item.rx_index = cnt_reg;
                                res.item.rx_byte  = in_item.bus_byte;
                                cnt_next          = cnt_inc;
                                res.item.action   = ACT_RECV;
                                res.item.ack_next = (remain > 10'sd1);
                            end else begin
                                res.item.action = ACT_STOP;
                                res.item.error  = 1'b1;
                                idle_next       = 1'b1;
                            end
                        end
                        ST_RX_NACK: begin
                            if (op_reg == OP_READ) begin
                                res.item.rx_valid  = 1'b1;
                                res.item.rx_index  = cnt_reg;
                                res.item.rx_byte   = in_item.bus_byte;
                                res.item.action    = ACT_STOP;
                                res.item.read_done = 1'b1;
                                idle_next          = 1'b1;
                            end else begin
                                res.item.action = ACT_STOP;
                                res.item.error  = 1'b1;
                                idle_next       = 1'b1;
                            end
                        end
                        default: begin
                            res.item.action = ACT_STOP;
                            res.item.error  = 1'b1;
                            idle_next       = 1'b1;
                        end
                    endcase
                end
            end
            MODE_LOAD: begin
                buf_req.wr_en = ({1'b0, in_item.buffer_index} < DEPTH9);
            end
            default: begin
            end
        endcase

        res.item.bus_free = idle_next;
        if (!accept) begin
            buf_req.wr_en = 1'b0;
            buf_req.rd_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg  <= 1'b1;
            op_reg    <= OP_NONE;
            addr_reg  <= '0;
            regad_reg <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end else if (accept) begin
            idle_reg  <= idle_next;
            op_reg    <= op_next;
            addr_reg  <= addr_next;
            regad_reg <= regad_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_start_claims: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && idle_reg && (mode == MODE_START_WR || mode == MODE_START_RD))
        |=> !idle_reg)
        else $error("start from idle did not claim the bus");

    a_busy_start_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !idle_reg && (mode == MODE_START_WR || mode == MODE_START_RD))
        |=> ($stable(len_reg) && $stable(addr_reg) && $stable(op_reg)))
        else $error("start while busy changed the transfer");

    a_error_frees_bus: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res.item.error) |=> idle_reg)
        else $error("aborted transfer left the bus claimed");

endmodule

FILE: src/i2cra_out.sv
// result pipeline: holding stage for the buffer read plus output register
module i2cra_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  i2cra_pkg::seq_res_t  res,
    input  logic [7:0]           buf_data,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cra_pkg::out_item_t m_data
);
    import i2cra_pkg::*;

    logic      st_valid_reg, st_valid_next;
    seq_res_t  st_res_reg;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;
    out_item_t merged;
    logic      advance;

    assign advance = st_valid_reg && (!m_valid_reg || m_ready);
    // no transaction is taken while reset is held
    assign s_ready = aresetn && (!st_valid_reg || advance);

    always_comb begin
        merged = st_res_reg.item;
        if (st_res_reg.from_buf) begin
            merged.send_byte = buf_data;
        end
    end

    always_comb begin
        st_valid_next = st_valid_reg;
        if (accept) begin
            st_valid_next = 1'b1;
        end else if (advance) begin
            st_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        if (accept) begin
            st_res_reg <= res;
        end
        if (advance) begin
            m_data_reg <= merged;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while both result stages are full");

endmodule

FILE: src/i2c_master_register_access_core.sv
// top level of the i2c master register access core
//
// one input channel (s_valid/s_ready/s_data) carries start commands, status
// events from the bus controller and transmit buffer loads; one result
// channel (m_valid/m_ready/m_data) returns exactly one result per input
// transaction, in order.
// a transaction is decoded in the cycle it is accepted; the transfer state
// updates at that edge and a data byte read issues to the buffer ram.
// the result shows on m_data once the output register loads: the buffer ram read
// and the holding stage load at the accepting edge, the output register when
// the holding stage advances.
// throughput is one transaction per cycle while m_ready stays high.
// a holding stage and the output register decouple the two sides: when
// m_ready drops, two results queue and then s_ready falls until one leaves.
// reset (aresetn low, synchronous) holds s_ready low, frees the bus, clears
// the transfer state and empties both result stages; buffer contents are not
// cleared and an entry must be loaded before a write transfer sends it.
module i2c_master_register_access_core #(
    parameter int BUFFER_DEPTH = i2cra_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2cra_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cra_pkg::out_item_t m_data
);
    import i2cra_pkg::*;

    logic       accept;
    seq_res_t   res;
    buf_req_t   buf_req;
    logic [7:0] buf_data;

    assign accept = s_valid && s_ready;

    i2cra_seq #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_item (s_data),
        .res     (res),
        .buf_req (buf_req)
    );

    i2cra_buf #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_buf (
        .aclk    (aclk),
        .req     (buf_req),
        .rd_data (buf_data)
    );

    i2cra_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .res      (res),
        .buf_data (buf_data),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

FILE: tb/i2c_master_register_access_core_tb.sv
// testbench for the i2c master register access core
module i2c_master_register_access_core_tb;
    import i2cra_pkg::*;

    localparam int BUF_DEPTH    = BUFFER_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_TAIL    = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int SHOW_LIMIT   = 10;
    localparam int DATA_CAP     = 16;

    // bus status codes outside the normal register access flow
    localparam logic [7:0] ST_SLAW_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST  = 8'h38;
    localparam logic [7:0] ST_SLAR_NACK = 8'h48;
    localparam logic [7:0] ST_NO_INFO   = 8'hF8;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } step_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // sequencer state as the testbench sees it
    logic       bus_idle;
    op_t        cur_op;
    logic [6:0] cur_sla;
    logic [7:0] cur_reg;
    logic [7:0] xfer_len;
    logic [7:0] xfer_cnt;
    logic [7:0] tx_mem [BUF_DEPTH];
    bit         tx_loaded [BUF_DEPTH];

    out_item_t pending_results[$];
    step_row_t script[$];

    int idle_pct     = 0;
    int fault_odds   = 12;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int checked      = 0;
    int counted      = 0;
    int writes_done  = 0;
    int reads_done   = 0;
    int aborts       = 0;
    int longest_read = 0;

    i2c_master_register_access_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic out_item_t next_bus_action(input in_item_t it);
        out_item_t  r;
        logic [7:0] st;
        int         left;
        r  = '0;
        st = it.status_code & STATUS_MASK;
        case (it.mode)
            MODE_START_WR, MODE_START_RD: begin
                if (bus_idle) begin
                    cur_sla  = it.slave_address;
                    cur_reg  = it.register_address;
                    xfer_len = it.byte_count;
                    cur_op   = (it.mode == MODE_START_WR) ? OP_WRITE : OP_READ;
                    bus_idle = 1'b0;
                    r.action = ACT_START;
                end
            end
            MODE_STATUS: begin
                // events are decoded by the last operation even once idle
                if (cur_op == OP_WRITE) begin
                    case (st)
                        ST_START: begin
                            xfer_cnt    = '0;
                            r.action    = ACT_SEND;
                            r.send_byte = {cur_sla, 1'b0};
                        end
                        ST_SLAW_ACK: begin
                            r.action    = ACT_SEND;
                            r.send_byte = cur_reg;
                        end
                        ST_DATA_ACK: begin
                            if (xfer_cnt < xfer_len) begin
                                r.action = ACT_SEND;
                                if (xfer_cnt < BUF_DEPTH) r.send_byte = tx_mem[xfer_cnt];
                                xfer_cnt = xfer_cnt + 8'd1;
                            end else begin
                                r.action = ACT_STOP;
                                bus_idle = 1'b1;
                            end
                        end
                        default: begin
                            r.action = ACT_STOP;
                            r.error  = 1'b1;
                            bus_idle = 1'b1;
                        end
                    endcase
                end else if (cur_op == OP_READ) begin
                    case (st)
                        ST_START: begin
                            xfer_cnt    = '0;
                            r.action    = ACT_SEND;
                            r.send_byte = {cur_sla, 1'b0};
                        end
                        ST_SLAW_ACK: begin
                            r.action    = ACT_SEND;
                            r.send_byte = cur_reg;
                        end
                        ST_DATA_ACK: r.action = ACT_RSTART;
                        ST_RSTART: begin
                            r.action    = ACT_SEND;
                            r.send_byte = {cur_sla, 1'b1};
                        end
                        ST_SLAR_ACK: begin
                            r.action   = ACT_RECV;
                            r.ack_next = (xfer_len > 8'd1);
                        end
                        ST_RX_ACK: begin
                            r.rx_valid = 1'b1;
                            r.rx_index = xfer_cnt;
                            r.rx_byte  = it.bus_byte;
                            xfer_cnt   = xfer_cnt + 8'd1;
                            // signed remainder, the counter may have run past the length
                            left       = int'(xfer_len) - int'(xfer_cnt);
                            r.action   = ACT_RECV;
                            r.ack_next = (left > 1);
                        end
                        ST_RX_NACK: begin
                            r.rx_valid  = 1'b1;
                            r.rx_index  = xfer_cnt;
                            r.rx_byte   = it.bus_byte;
                            r.action    = ACT_STOP;
                            r.read_done = 1'b1;
                            bus_idle    = 1'b1;
                        end
                        default: begin
                            r.action = ACT_STOP;
                            r.error  = 1'b1;
                            bus_idle = 1'b1;
                        end
                    endcase
                end
            end
            MODE_LOAD: begin
                if (it.buffer_index < BUF_DEPTH) begin
                    tx_mem[it.buffer_index]    = it.bus_byte;
                    tx_loaded[it.buffer_index] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.bus_free = bus_idle;
        return r;
    endfunction

    function automatic in_item_t rand_item();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t cmd(input mode_t md, input logic [6:0] sla,
                                     input logic [7:0] rg, input logic [7:0] cnt);
        in_item_t it;
        it                  = '0;
        it.mode             = md;
        it.slave_address    = sla;
        it.register_address = rg;
        it.byte_count       = cnt;
        return it;
    endfunction

    function automatic in_item_t evt(input logic [7:0] st, input logic [7:0] b);
        in_item_t it;
        it             = '0;
        it.mode        = MODE_STATUS;
        it.status_code = st;
        it.bus_byte    = b;
        return it;
    endfunction

    function automatic in_item_t ld(input logic [7:0] idx, input logic [7:0] b);
        in_item_t it;
        it              = '0;
        it.mode         = MODE_LOAD;
        it.buffer_index = idx;
        it.bus_byte     = b;
        return it;
    endfunction

    function automatic out_item_t res(input action_t a, input logic [7:0] sb,
                                      input logic err, input logic free);
        out_item_t r;
        r           = '0;
        r.action    = a;
        r.send_byte = sb;
        r.error     = err;
        r.bus_free  = free;
        return r;
    endfunction

    function automatic void row(input in_item_t stim, input bit typed = 1'b0,
                                input out_item_t want = '0);
        step_row_t s;
        s.stim  = stim;
        s.typed = typed;
        s.want  = want;
        script.push_back(s);
    endfunction

    task automatic issue(input in_item_t stim, input bit typed = 1'b0,
                         input out_item_t want = '0);
        out_item_t pred;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= stim;
        do @(posedge aclk); while (!s_ready);
        pred = next_bus_action(stim);
        pending_results.push_back(typed ? want : pred);
        if (pred.action != ACT_NONE || stim.mode == MODE_LOAD) counted++;
        if (pred.read_done) reads_done++;
        if (pred.error) aborts++;
        if (pred.action == ACT_STOP && !pred.error && !pred.read_done) writes_done++;
    endtask

    // never let a write transfer send a buffer entry that was not loaded
    task automatic feed(input in_item_t stim);
        in_item_t fill;
        if (stim.mode == MODE_STATUS && cur_op == OP_WRITE
                && (stim.status_code & STATUS_MASK) == ST_DATA_ACK
                && xfer_cnt < xfer_len && !tx_loaded[xfer_cnt]) begin
            fill              = rand_item();
            fill.mode         = MODE_LOAD;
            fill.buffer_index = xfer_cnt;
            issue(fill);
        end
        issue(stim);
    endtask

    task automatic status_step(input logic [7:0] code, input bit brk, inout bit alive);
        in_item_t ev;
        if (alive) begin
            if ($urandom_range(0, 24) == 0) feed(rand_item());
            ev      = rand_item();
            ev.mode = MODE_STATUS;
            if (brk || (fault_odds != 0 && $urandom_range(1, fault_odds) == 1)) begin
                alive = 1'b0;
                case ($urandom_range(0, 5))
                    0:       code = ST_SLAW_NACK;
                    1:       code = ST_DATA_NACK;
                    2:       code = ST_ARB_LOST;
                    3:       code = ST_SLAR_NACK;
                    4:       code = ST_NO_INFO;
                    default: code = {5'($urandom_range(0, 31)), 3'b000};
                endcase
            end
            ev.status_code = code | 8'($urandom_range(0, 7));
            feed(ev);
        end
    endtask

    task automatic report(input string what, input out_item_t want, input out_item_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
            $display("result %0d: %s", checked, what);
            $display("  expected act=%0d send=%h ack=%b rxv=%b idx=%0d rx=%h done=%b err=%b free=%b",
                     want.action, want.send_byte, want.ack_next, want.rx_valid, want.rx_index,
                     want.rx_byte, want.read_done, want.error, want.bus_free);
            $display("  actual   act=%0d send=%h ack=%b rxv=%b idx=%0d rx=%h done=%b err=%b free=%b",
                     got.action, got.send_byte, got.ack_next, got.rx_valid, got.rx_index,
                     got.rx_byte, got.read_done, got.error, got.bus_free);
        end
    endtask

    // result side: random stall bursts and the in-order check
    always @(posedge aclk) begin
        out_item_t want;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            hold_left <= $urandom_range(0, 11);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            checked++;
            if (pending_results.size() == 0) begin
                report("result with no transaction waiting", '0, m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want) report("field mismatch", want, m_data);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        in_item_t it;
        bit       is_rd;
        bit       alive;
        bit       brk_end;
        bit       did_long;
        int       len;
        int       n_data;

        bus_idle = 1'b1;
        cur_op   = OP_NONE;
        cur_sla  = '0;
        cur_reg  = '0;
        xfer_len = '0;
        xfer_cnt = '0;
        did_long = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        row(evt(ST_START, 8'h00), 1'b1, res(ACT_NONE, 8'h00, 1'b0, 1'b1));
        row(ld(8'h00, 8'h00), 1'b1, res(ACT_NONE, 8'h00, 1'b0, 1'b1));
        row(ld(8'hFF, 8'hFF), 1'b1, res(ACT_NONE, 8'h00, 1'b0, 1'b1));
        row(ld(8'h01, 8'hA5));
        row(cmd(MODE_START_WR, 7'h7F, 8'hFF, 8'd2), 1'b1, res(ACT_START, 8'h00, 1'b0, 1'b0));
        row(cmd(MODE_START_RD, 7'h00, 8'h00, 8'hFF), 1'b1, res(ACT_NONE, 8'h00, 1'b0, 1'b0));
        row(evt(ST_START | 8'h07, 8'hFF), 1'b1, res(ACT_SEND, 8'hFE, 1'b0, 1'b0));
        row(evt(ST_SLAW_ACK, 8'h00), 1'b1, res(ACT_SEND, 8'hFF, 1'b0, 1'b0));
        row(evt(ST_DATA_ACK, 8'h00));
        row(evt(ST_DATA_ACK, 8'h00));
        row(evt(ST_DATA_ACK, 8'h00), 1'b1, res(ACT_STOP, 8'h00, 1'b0, 1'b1));
        row(evt(ST_DATA_ACK, 8'h00));
        row(cmd(MODE_START_RD, 7'h00, 8'h00, 8'd0), 1'b1, res(ACT_START, 8'h00, 1'b0, 1'b0));
        row(evt(ST_START, 8'h00), 1'b1, res(ACT_SEND, 8'h00, 1'b0, 1'b0));
        row(evt(ST_SLAW_ACK, 8'h00), 1'b1, res(ACT_SEND, 8'h00, 1'b0, 1'b0));
        row(evt(ST_DATA_ACK, 8'h00), 1'b1, res(ACT_RSTART, 8'h00, 1'b0, 1'b0));
        row(evt(ST_RSTART, 8'h00), 1'b1, res(ACT_SEND, 8'h01, 1'b0, 1'b0));
        row(evt(ST_SLAR_ACK, 8'h00));
        row(evt(ST_RX_NACK, 8'hFF));
        row(cmd(MODE_START_RD, 7'h55, 8'h80, 8'hFF), 1'b1, res(ACT_START, 8'h00, 1'b0, 1'b0));
        row(evt(ST_SLAR_ACK, 8'h00));
        row(evt(ST_RX_ACK, 8'h5A));
        row(evt(ST_NO_INFO, 8'h00), 1'b1, res(ACT_STOP, 8'h00, 1'b1, 1'b1));
        row(cmd(MODE_START_WR, 7'h00, 8'h00, 8'hFF), 1'b1, res(ACT_START, 8'h00, 1'b0, 1'b0));
        row(evt(ST_SLAW_NACK, 8'h00), 1'b1, res(ACT_STOP, 8'h00, 1'b1, 1'b1));

        idle_pct = 20;
        foreach (script[i]) issue(script[i].stim, script[i].typed, script[i].want);

        // random part: mostly well-formed transfers, some noise and broken ones
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted >= RANDOM_ITEMS - CALM_TAIL) begin
                idle_pct = 0;
            end else if ($urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end
            if ($urandom_range(0, 9) == 0) begin
                feed(rand_item());
            end else begin
                is_rd = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 19))
                    0:             len = $urandom_range(0, 255);
                    1, 2, 3, 4, 5: len = $urandom_range(5, DATA_CAP);
                    default:       len = $urandom_range(0, 4);
                endcase
                fault_odds = 12;
                brk_end    = 1'b0;
                if (is_rd && !did_long && counted > 300) begin
                    // one long read so the receive index wraps past 255
                    len        = $urandom_range(250, 255);
                    n_data     = 258;
                    fault_odds = 0;
                    did_long   = 1'b1;
                end else begin
                    n_data = is_rd ? ((len > 0) ? len - 1 : 0) : len;
                    if (n_data > DATA_CAP) begin
                        n_data  = DATA_CAP;
                        brk_end = 1'b1;
                    end
                    if (is_rd && $urandom_range(0, 7) == 0) n_data += $urandom_range(1, 3);
                end
                if (!is_rd && $urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(1, 4)) begin
                        it              = rand_item();
                        it.mode         = MODE_LOAD;
                        it.buffer_index = 8'($urandom_range(0, len));
                        feed(it);
                    end
                end
                it            = rand_item();
                it.mode       = is_rd ? MODE_START_RD : MODE_START_WR;
                it.byte_count = 8'(len);
                feed(it);
                alive = 1'b1;
                status_step(ST_START, 1'b0, alive);
                status_step(ST_SLAW_ACK, 1'b0, alive);
                if (is_rd) begin
                    status_step(ST_DATA_ACK, 1'b0, alive);
                    status_step(ST_RSTART, 1'b0, alive);
                    status_step(ST_SLAR_ACK, 1'b0, alive);
                    repeat (n_data) status_step(ST_RX_ACK, 1'b0, alive);
                    status_step(ST_RX_NACK, brk_end, alive);
                    if (alive && n_data + 1 > longest_read) longest_read = n_data + 1;
                end else begin
                    repeat (n_data) status_step(ST_DATA_ACK, 1'b0, alive);
                    status_step(ST_DATA_ACK, brk_end, alive);
                end
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("checked %0d results: %0d writes and %0d reads completed, %0d transfers aborted",
                 checked, writes_done, reads_done, aborts);
        $display("longest completed read took %0d bytes", longest_read);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: i2c_master_register_access_core.f
src/i2cra_pkg.sv
src/i2cra_buf.sv
src/i2cra_seq.sv
src/i2cra_out.sv
src/i2c_master_register_access_core.sv
tb/i2c_master_register_access_core_tb.sv
